### design/mse_pkg.sv
// shared types and constants of the product sparsity estimator
// no dependencies; the files that use it refer to it by scoped names
package mse_pkg;

  localparam int CW            = 16;
  localparam int P_W           = 2 * CW;
  localparam int LOG_TERMS     = 64;
  localparam int EXP_TERMS     = 20;
  localparam int EXP_SQUARINGS = 6;
  localparam int ADDR_W        = 5;

  localparam logic [1:0] MODE_EXACT   = 2'd0;
  localparam logic [1:0] MODE_EXT     = 2'd1;
  localparam logic [1:0] MODE_GENERIC = 2'd2;
  // spare code, runs as generic
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  localparam logic [2:0] REG_MODE          = 3'd0;
  localparam logic [2:0] REG_NNZ_ROWS_A    = 3'd1;
  localparam logic [2:0] REG_SINGLE_ROWS_A = 3'd2;
  localparam logic [2:0] REG_NNZ_COLS_B    = 3'd3;
  localparam logic [2:0] REG_SINGLE_COLS_B = 3'd4;
  localparam logic [2:0] REG_HALF_ROWS_A   = 3'd5;
  localparam logic [2:0] REG_HALF_COLS_B   = 3'd6;
  localparam logic [2:0] REG_OUTPUT_CELLS  = 3'd7;

  localparam logic [47:0] EST_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] Q63_ONE  = 64'h8000_0000_0000_0000;
  localparam logic [32:0] Q32_ONE  = 33'h1_0000_0000;

  typedef struct packed {
    logic [1:0]    mode;
    logic [CW-1:0] nnz_rows_a;
    logic [CW-1:0] single_rows_a;
    logic [CW-1:0] nnz_cols_b;
    logic [CW-1:0] single_cols_b;
    logic [CW-1:0] half_rows_a;
    logic [CW-1:0] half_cols_b;
    logic [31:0]   output_cells;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD_P, OP_FRAC_ZERO, OP_FRAC_ONE, OP_UDIV_GO, OP_U_LATCH,
    OP_LDIV_GO, OP_LSUM_ADD, OP_LMUL_GO, OP_PW_LATCH, OP_XMUL_GO, OP_X_LATCH,
    OP_EMUL_GO, OP_EDIV_GO, OP_TERM_ADD, OP_SQ_GO, OP_SQ_LATCH, OP_FRAC_EXP,
    OP_PMUL_GO, OP_TOTAL, OP_LOWER, OP_DENS_SAT, OP_DDIV_GO, OP_DENS_LATCH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   acc_en;
    logic   clear;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic trivial_zero;
    logic p_one;
    logic x_big;
    logic log_end;
    logic exp_end;
    logic sq_end;
    logic dens_sat;
  } dp_status_t;

  typedef enum logic [5:0] {
    ST_ACC, ST_P, ST_CHK, ST_UDIV, ST_UDIV_W, ST_U, ST_LDIV, ST_LDIV_W, ST_LSUM,
    ST_LMUL, ST_LMUL_W, ST_PW, ST_XMUL, ST_XMUL_W, ST_XCHK, ST_EMUL, ST_EMUL_W,
    ST_EDIV, ST_EDIV_W, ST_TERM, ST_SQ, ST_SQ_W, ST_SQL, ST_FRAC, ST_PMUL,
    ST_PMUL_W, ST_TOTAL, ST_LOWER, ST_DCHK, ST_DDIV, ST_DDIV_W, ST_DLATCH, ST_OUT
  } state_t;

endpackage

### design/mse_mul.sv
// 64x64 multiplier, four 32x32 partial products accumulated one per cycle
// depends on nothing but its ports
module mse_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic [127:0]  prod,
  output logic          done
);

  logic [63:0]  a_r, b_r;
  logic [127:0] prod_r;
  logic [1:0]   cnt_r;
  logic         busy_r, done_r;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic [127:0] pp_ext;

  assign pp     = 64'(a_r[32*cnt_r[1] +: 32]) * 64'(b_r[32*cnt_r[0] +: 32]);
  assign sh     = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
  assign pp_ext = {64'b0, pp} << {sh, 5'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      prod_r <= '0;
    end else if (busy_r) begin
      prod_r <= prod_r + pp_ext;
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

### design/mse_div.sv
// restoring divider, 64-bit dividend and divisor, one quotient bit per cycle
// depends on nothing but its ports
module mse_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic [63:0] quotient,
  output logic        done
);

  logic [63:0] rem_r, quo_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[63]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? 64'(trial - {1'b0, dvs_r}) : trial[63:0];
      quo_r <= {quo_r[62:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

### design/mse_regs.sv
// configuration register file behind the apb-style port
// depends on mse_pkg
module mse_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mse_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output mse_pkg::cfg_t             cfg
);

  mse_pkg::cfg_t cfg_r;
  logic          wr;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mode: '0, nnz_rows_a: '0, single_rows_a: '0, nnz_cols_b: '0,
                 single_cols_b: '0, half_rows_a: '0, half_cols_b: '0,
                 output_cells: 32'd1};
    end else if (wr) begin
      case (idx)
        mse_pkg::REG_MODE:          cfg_r.mode          <= pwdata[1:0];
        mse_pkg::REG_NNZ_ROWS_A:    cfg_r.nnz_rows_a    <= pwdata[mse_pkg::CW-1:0];
        mse_pkg::REG_SINGLE_ROWS_A: cfg_r.single_rows_a <= pwdata[mse_pkg::CW-1:0];
        mse_pkg::REG_NNZ_COLS_B:    cfg_r.nnz_cols_b    <= pwdata[mse_pkg::CW-1:0];
        mse_pkg::REG_SINGLE_COLS_B: cfg_r.single_cols_b <= pwdata[mse_pkg::CW-1:0];
        mse_pkg::REG_HALF_ROWS_A:   cfg_r.half_rows_a   <= pwdata[mse_pkg::CW-1:0];
        mse_pkg::REG_HALF_COLS_B:   cfg_r.half_cols_b   <= pwdata[mse_pkg::CW-1:0];
        mse_pkg::REG_OUTPUT_CELLS:  cfg_r.output_cells  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mse_pkg::REG_MODE:          prdata = 32'(cfg_r.mode);
      mse_pkg::REG_NNZ_ROWS_A:    prdata = 32'(cfg_r.nnz_rows_a);
      mse_pkg::REG_SINGLE_ROWS_A: prdata = 32'(cfg_r.single_rows_a);
      mse_pkg::REG_NNZ_COLS_B:    prdata = 32'(cfg_r.nnz_cols_b);
      mse_pkg::REG_SINGLE_COLS_B: prdata = 32'(cfg_r.single_cols_b);
      mse_pkg::REG_HALF_ROWS_A:   prdata = 32'(cfg_r.half_rows_a);
      mse_pkg::REG_HALF_COLS_B:   prdata = 32'(cfg_r.half_cols_b);
      mse_pkg::REG_OUTPUT_CELLS:  prdata = cfg_r.output_cells;
      default:                    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### design/mse_dp.sv
// datapath: accumulators, log/exp registers, shared multiplier and divider
// depends on mse_pkg, mse_mul, mse_div
module mse_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mse_pkg::dp_cmd_t      cmd,
  input  mse_pkg::cfg_t         cfg,
  input  logic [mse_pkg::CW-1:0] ca,
  input  logic [mse_pkg::CW-1:0] cs,
  input  logic [mse_pkg::CW-1:0] rb,
  input  logic [mse_pkg::CW-1:0] rs,
  output mse_pkg::dp_status_t   status,
  output logic [47:0]           est,
  output logic [31:0]           dens
);

  localparam int CW  = mse_pkg::CW;
  localparam int P_W = mse_pkg::P_W;

  logic [63:0] exact_r, hit_r, total_r;
  logic [P_W-1:0] p_r;
  logic [63:0] u_r, pw_r, lsum_r, r_r, term_r, acc_r;
  logic [32:0] frac_r;
  logic [31:0] dens_r;
  logic [6:0]  k_r;

  logic [CW-1:0]  dca, drb, dr, dc;
  logic [P_W-1:0] m_carb, m_csrb, m_rsd, m_dd, p_nxt, lower;
  logic [64:0]    tsum;
  logic [63:0]    acc_sq;

  logic         mul_start, div_start, mul_done, div_done;
  logic [63:0]  mul_a, mul_b, div_n, div_d, quo;
  logic [127:0] prod;

  assign dca    = (ca > cs) ? ca - cs : '0;
  assign drb    = (rb > rs) ? rb - rs : '0;
  assign m_carb = P_W'(ca) * P_W'(rb);
  assign m_csrb = P_W'(cs) * P_W'(rb);
  assign m_rsd  = P_W'(rs) * P_W'(dca);
  assign m_dd   = P_W'(dca) * P_W'(drb);

  assign dr = (cfg.nnz_rows_a > cfg.single_rows_a) ?
              cfg.nnz_rows_a - cfg.single_rows_a : '0;
  assign dc = (cfg.nnz_cols_b > cfg.single_cols_b) ?
              cfg.nnz_cols_b - cfg.single_cols_b : '0;

  always_comb begin
    case (cfg.mode)
      mse_pkg::MODE_EXACT: p_nxt = '0;
      mse_pkg::MODE_EXT:   p_nxt = P_W'(dr) * P_W'(dc);
      default:             p_nxt = P_W'(cfg.nnz_rows_a) * P_W'(cfg.nnz_cols_b);
    endcase
  end

  assign lower = P_W'(cfg.half_rows_a) * P_W'(cfg.half_cols_b);
  assign tsum  = {1'b0, exact_r} + {1'b0, prod[95:32]};
  assign acc_sq = prod[126:63];

  // accumulators, reset to zero and cleared once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      exact_r <= '0;
      hit_r   <= '0;
    end else if (cmd.acc_en) begin
      case (cfg.mode)
        mse_pkg::MODE_EXACT: exact_r <= exact_r + 64'(m_carb);
        mse_pkg::MODE_EXT: begin
          exact_r <= exact_r + 64'(m_csrb) + 64'(m_rsd);
          hit_r   <= hit_r + 64'(m_dd);
        end
        default: hit_r <= hit_r + 64'(m_carb);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mse_pkg::OP_LOAD_P: begin
        p_r    <= p_nxt;
        lsum_r <= '0;
      end
      mse_pkg::OP_FRAC_ZERO: frac_r <= '0;
      mse_pkg::OP_FRAC_ONE:  frac_r <= mse_pkg::Q32_ONE;
      mse_pkg::OP_U_LATCH: begin
        u_r  <= quo;
        pw_r <= quo;
        k_r  <= 7'd1;
      end
      mse_pkg::OP_LSUM_ADD: lsum_r <= lsum_r + quo;
      mse_pkg::OP_PW_LATCH: begin
        pw_r <= prod[127:64];
        k_r  <= k_r + 7'd1;
      end
      mse_pkg::OP_X_LATCH: begin
        // q64.64 argument divided by 64, as q1.63
        r_r    <= {prod[70:32], 25'b0};
        term_r <= mse_pkg::Q63_ONE;
        acc_r  <= mse_pkg::Q63_ONE;
        k_r    <= 7'd1;
      end
      mse_pkg::OP_TERM_ADD: begin
        term_r <= quo;
        acc_r  <= k_r[0] ? acc_r - quo : acc_r + quo;
        k_r    <= status.exp_end ? 7'd0 : k_r + 7'd1;
      end
      mse_pkg::OP_SQ_LATCH: begin
        acc_r <= acc_sq;
        k_r   <= k_r + 7'd1;
      end
      mse_pkg::OP_FRAC_EXP: frac_r <= 33'(mse_pkg::Q32_ONE - 33'(acc_r >> 31));
      mse_pkg::OP_TOTAL:    total_r <= tsum[64] ? '1 : tsum[63:0];
      mse_pkg::OP_LOWER:    if (total_r < 64'(lower)) total_r <= 64'(lower);
      mse_pkg::OP_DENS_SAT: dens_r <= '1;
      mse_pkg::OP_DENS_LATCH: dens_r <= quo[31:0];
      default: ;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_start = 1'b1;
    mul_a     = pw_r;
    mul_b     = u_r;
    case (cmd.op)
      mse_pkg::OP_LMUL_GO: begin mul_a = pw_r;       mul_b = u_r;          end
      mse_pkg::OP_XMUL_GO: begin mul_a = hit_r;      mul_b = lsum_r;       end
      mse_pkg::OP_EMUL_GO: begin mul_a = term_r;     mul_b = r_r;          end
      mse_pkg::OP_SQ_GO:   begin mul_a = acc_r;      mul_b = acc_r;        end
      mse_pkg::OP_PMUL_GO: begin mul_a = 64'(p_r);   mul_b = 64'(frac_r);  end
      default: mul_start = 1'b0;
    endcase
  end

  // shared divider operands
  always_comb begin
    div_start = 1'b1;
    div_n     = pw_r;
    div_d     = 64'(k_r);
    case (cmd.op)
      mse_pkg::OP_UDIV_GO: begin div_n = '1;               div_d = 64'(p_r); end
      mse_pkg::OP_LDIV_GO: begin div_n = pw_r;             div_d = 64'(k_r); end
      mse_pkg::OP_EDIV_GO: begin div_n = prod[126:63];     div_d = 64'(k_r); end
      mse_pkg::OP_DDIV_GO: begin
        div_n = {total_r[31:0], 32'b0};
        div_d = 64'(cfg.output_cells);
      end
      default: div_start = 1'b0;
    endcase
  end

  mse_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  mse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    status.mul_done     = mul_done;
    status.div_done     = div_done;
    status.trivial_zero = (p_r == '0) || (hit_r == '0);
    status.p_one        = (p_r == P_W'(1));
    status.x_big        = prod[127:64] >= 64'd32;
    status.log_end      = k_r == 7'(mse_pkg::LOG_TERMS);
    status.exp_end      = k_r == 7'(mse_pkg::EXP_TERMS);
    status.sq_end       = k_r == 7'(mse_pkg::EXP_SQUARINGS - 1);
    status.dens_sat     = (cfg.output_cells == '0) ||
                          (total_r >= 64'(cfg.output_cells));
  end

  assign est  = (total_r > 64'(mse_pkg::EST_MAX)) ? mse_pkg::EST_MAX : total_r[47:0];
  assign dens = dens_r;

endmodule

### design/mse_ctrl.sv
// controller: sequences accumulation, the log series, the exp series and output
// depends on mse_pkg
module mse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  input  logic                out_ready,
  input  mse_pkg::dp_status_t status,
  output logic                in_ready,
  output logic                out_valid,
  output mse_pkg::dp_cmd_t    cmd
);

  mse_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mse_pkg::ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = mse_pkg::OP_NONE;
    cmd.acc_en = 1'b0;
    cmd.clear  = 1'b0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      mse_pkg::ST_ACC: begin
        in_ready   = 1'b1;
        cmd.acc_en = in_valid;
        if (in_valid && in_last) state_nxt = mse_pkg::ST_P;
      end
      mse_pkg::ST_P: begin
        cmd.op    = mse_pkg::OP_LOAD_P;
        state_nxt = mse_pkg::ST_CHK;
      end
      mse_pkg::ST_CHK: begin
        if (status.trivial_zero) begin
          cmd.op    = mse_pkg::OP_FRAC_ZERO;
          state_nxt = mse_pkg::ST_PMUL;
        end else if (status.p_one) begin
          cmd.op    = mse_pkg::OP_FRAC_ONE;
          state_nxt = mse_pkg::ST_PMUL;
        end else begin
          state_nxt = mse_pkg::ST_UDIV;
        end
      end
      mse_pkg::ST_UDIV: begin
        cmd.op    = mse_pkg::OP_UDIV_GO;
        state_nxt = mse_pkg::ST_UDIV_W;
      end
      mse_pkg::ST_UDIV_W: if (status.div_done) state_nxt = mse_pkg::ST_U;
      mse_pkg::ST_U: begin
        cmd.op    = mse_pkg::OP_U_LATCH;
        state_nxt = mse_pkg::ST_LDIV;
      end
      mse_pkg::ST_LDIV: begin
        cmd.op    = mse_pkg::OP_LDIV_GO;
        state_nxt = mse_pkg::ST_LDIV_W;
      end
      mse_pkg::ST_LDIV_W: if (status.div_done) state_nxt = mse_pkg::ST_LSUM;
      mse_pkg::ST_LSUM: begin
        cmd.op    = mse_pkg::OP_LSUM_ADD;
        state_nxt = status.log_end ? mse_pkg::ST_XMUL : mse_pkg::ST_LMUL;
      end
      mse_pkg::ST_LMUL: begin
        cmd.op    = mse_pkg::OP_LMUL_GO;
        state_nxt = mse_pkg::ST_LMUL_W;
      end
      mse_pkg::ST_LMUL_W: if (status.mul_done) state_nxt = mse_pkg::ST_PW;
      mse_pkg::ST_PW: begin
        cmd.op    = mse_pkg::OP_PW_LATCH;
        state_nxt = mse_pkg::ST_LDIV;
      end
      mse_pkg::ST_XMUL: begin
        cmd.op    = mse_pkg::OP_XMUL_GO;
        state_nxt = mse_pkg::ST_XMUL_W;
      end
      mse_pkg::ST_XMUL_W: if (status.mul_done) state_nxt = mse_pkg::ST_XCHK;
      mse_pkg::ST_XCHK: begin
        if (status.x_big) begin
          cmd.op    = mse_pkg::OP_FRAC_ONE;
          state_nxt = mse_pkg::ST_PMUL;
        end else begin
          cmd.op    = mse_pkg::OP_X_LATCH;
          state_nxt = mse_pkg::ST_EMUL;
        end
      end
      mse_pkg::ST_EMUL: begin
        cmd.op    = mse_pkg::OP_EMUL_GO;
        state_nxt = mse_pkg::ST_EMUL_W;
      end
      mse_pkg::ST_EMUL_W: if (status.mul_done) state_nxt = mse_pkg::ST_EDIV;
      mse_pkg::ST_EDIV: begin
        cmd.op    = mse_pkg::OP_EDIV_GO;
        state_nxt = mse_pkg::ST_EDIV_W;
      end
      mse_pkg::ST_EDIV_W: if (status.div_done) state_nxt = mse_pkg::ST_TERM;
      mse_pkg::ST_TERM: begin
        cmd.op    = mse_pkg::OP_TERM_ADD;
        state_nxt = status.exp_end ? mse_pkg::ST_SQ : mse_pkg::ST_EMUL;
      end
      mse_pkg::ST_SQ: begin
        cmd.op    = mse_pkg::OP_SQ_GO;
        state_nxt = mse_pkg::ST_SQ_W;
      end
      mse_pkg::ST_SQ_W: if (status.mul_done) state_nxt = mse_pkg::ST_SQL;
      mse_pkg::ST_SQL: begin
        cmd.op    = mse_pkg::OP_SQ_LATCH;
        state_nxt = status.sq_end ? mse_pkg::ST_FRAC : mse_pkg::ST_SQ;
      end
      mse_pkg::ST_FRAC: begin
        cmd.op    = mse_pkg::OP_FRAC_EXP;
        state_nxt = mse_pkg::ST_PMUL;
      end
      mse_pkg::ST_PMUL: begin
        cmd.op    = mse_pkg::OP_PMUL_GO;
        state_nxt = mse_pkg::ST_PMUL_W;
      end
      mse_pkg::ST_PMUL_W: if (status.mul_done) state_nxt = mse_pkg::ST_TOTAL;
      mse_pkg::ST_TOTAL: begin
        cmd.op    = mse_pkg::OP_TOTAL;
        state_nxt = mse_pkg::ST_LOWER;
      end
      mse_pkg::ST_LOWER: begin
        cmd.op    = mse_pkg::OP_LOWER;
        state_nxt = mse_pkg::ST_DCHK;
      end
      mse_pkg::ST_DCHK: begin
        if (status.dens_sat) begin
          cmd.op    = mse_pkg::OP_DENS_SAT;
          state_nxt = mse_pkg::ST_OUT;
        end else begin
          state_nxt = mse_pkg::ST_DDIV;
        end
      end
      mse_pkg::ST_DDIV: begin
        cmd.op    = mse_pkg::OP_DDIV_GO;
        state_nxt = mse_pkg::ST_DDIV_W;
      end
      mse_pkg::ST_DDIV_W: if (status.div_done) state_nxt = mse_pkg::ST_DLATCH;
      mse_pkg::ST_DLATCH: begin
        cmd.op    = mse_pkg::OP_DENS_LATCH;
        state_nxt = mse_pkg::ST_OUT;
      end
      mse_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_nxt = mse_pkg::ST_ACC;
        end
      end
      default: state_nxt = mse_pkg::ST_ACC;
    endcase
  end

endmodule

### design/mnc_product_sparsity_estimator.sv
// top level of the sketch-based product sparsity estimator
// depends on mse_pkg, mse_regs, mse_ctrl, mse_dp (and mse_mul, mse_div below it)
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | sink      | in_tvalid / in_tready | in_tdata (4 counts), in_tlast
//   out     | source    | out_tvalid/out_tready | out_tdata (estimate, density)
//   cfg     | apb slave | psel/penable/pready   | paddr, pwdata, prdata
//
// items without last are accumulated at one per cycle
// an item with last starts the final sequence; the log and exp series, skipped when p or
// the hit sum is 0 or p is 1, run the 64-step divider once per log term and per exp term
// input is held off from the last item until the result is taken; out_tvalid then
// holds with its data until out_tready
// rst_n is synchronous, active low; accumulators clear on reset and after each result
module mnc_product_sparsity_estimator (
  input  logic                        clk,
  input  logic                        rst_n,
  // [15:0] col_count_a, [31:16] col_single_a, [47:32] row_count_b, [63:48] row_single_b
  input  logic [4*mse_pkg::CW-1:0]    in_tdata,
  input  logic                        in_tlast,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [47:0] estimated_nonzeros, [79:48] density_q32
  output logic [79:0]                 out_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mse_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CW = mse_pkg::CW;

  mse_pkg::cfg_t       cfg;
  mse_pkg::dp_cmd_t    cmd;
  mse_pkg::dp_status_t status;
  logic [47:0]         est;
  logic [31:0]         dens;

  mse_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // controller owns the handshakes, datapath never sees them directly
  mse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .out_ready (out_tready),
    .status    (status),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  mse_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .cfg    (cfg),
    .ca     (in_tdata[0*CW +: CW]),
    .cs     (in_tdata[1*CW +: CW]),
    .rb     (in_tdata[2*CW +: CW]),
    .rs     (in_tdata[3*CW +: CW]),
    .status (status),
    .est    (est),
    .dens   (dens)
  );

  // result registers in the datapath hold steady while out_tvalid waits
  assign out_tdata = {dens, est};

endmodule
